// ----- rtl/ipcmb_pkg.sv -----
// Shared types and constants for the interprocessor mailbox.
// Used by ipcmb_ctrl, ipcmb_datapath and interprocessor_fifo_mailbox.
package ipcmb_pkg;

  // Opcode values
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register select codes
  localparam logic [1:0] REG_SYNC = 2'd0;
  localparam logic [1:0] REG_CTRL = 2'd1;
  localparam logic [1:0] REG_DATA = 2'd2;

  // Control register bit positions
  localparam int unsigned CTL_SEND_EMPTY = 0;
  localparam int unsigned CTL_SEND_FULL  = 1;
  localparam int unsigned CTL_SEND_IRQ   = 2;
  localparam int unsigned CTL_FLUSH      = 3;
  localparam int unsigned CTL_RECV_EMPTY = 8;
  localparam int unsigned CTL_RECV_FULL  = 9;
  localparam int unsigned CTL_RECV_IRQ   = 10;
  localparam int unsigned CTL_ERROR      = 14;
  localparam int unsigned CTL_ENABLE     = 15;

  localparam logic [3:0] NIBBLE_MASK = 4'hf;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EXEC   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming access
    logic exec;    // apply the access to the mailbox state
    logic finish;  // load the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_busy;  // output register holds a transfer that is stalled
  } status_t;

endpackage

// ----- rtl/ipcmb_ctrl.sv -----
// Mailbox controller: sequences each access through execute and finish.
// Depends on ipcmb_pkg.
module ipcmb_ctrl import ipcmb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register can take the result
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/ipcmb_datapath.sv -----
// Mailbox datapath: access registers, FIFO store, pointers, flags, output register.
// Depends on ipcmb_pkg; driven by ipcmb_ctrl commands.
module ipcmb_datapath import ipcmb_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic        side_i,
  input  logic        opcode_i,
  input  logic [1:0]  reg_select_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        irq_side_zero_o,
  output logic        irq_side_one_o
);

  localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned AW = $clog2(2 * FIFO_DEPTH);
  localparam int unsigned MEM_WORDS = 2 * FIFO_DEPTH;

  // captured access
  logic        side_q;
  logic        op_q;
  logic [1:0]  sel_q;
  logic [31:0] wdata_q;

  // mailbox state, indexed by side / FIFO number
  logic [PW-1:0] rptr_q [2];
  logic [PW-1:0] wptr_q [2];
  logic [CW-1:0] cnt_q  [2];
  logic [1:0]    enable_q;
  logic [1:0]    send_irq_en_q;
  logic [1:0]    recv_irq_en_q;
  logic [1:0]    err_q;
  logic [3:0]    sync_q [2];
  logic [31:0]   last_q [2];

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] mem_rd_q;

  logic [31:0] stage_q;
  logic        pop_q;

  logic [31:0] out_data_q;
  logic        out_irq0_q, out_irq1_q;
  logic        out_valid_q;

  logic        oth;
  logic [1:0]  empty, full;
  logic        do_push, do_pop, push_err, pop_err;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] ctl_val, sync_val;
  logic [1:0]  irq;

  assign oth = ~side_q;

  always_comb begin
    for (int q = 0; q < 2; q++) begin
      empty[q] = (cnt_q[q] == '0);
      full[q]  = (cnt_q[q] == CW'(FIFO_DEPTH));
    end
  end

  always_comb begin
    irq[0] = (send_irq_en_q[0] & empty[0]) | (recv_irq_en_q[0] & ~empty[1]);
    irq[1] = (send_irq_en_q[1] & empty[1]) | (recv_irq_en_q[1] & ~empty[0]);
  end

  // data port decode
  always_comb begin
    do_push  = 1'b0;
    push_err = 1'b0;
    do_pop   = 1'b0;
    pop_err  = 1'b0;
    if (cmd_i.exec && sel_q == REG_DATA && enable_q[side_q]) begin
      if (op_q == OP_WRITE) begin
        push_err = full[side_q];
        do_push  = ~full[side_q];
      end else begin
        pop_err = empty[oth];
        do_pop  = ~empty[oth];
      end
    end
  end

  assign waddr = side_q ? (AW'(FIFO_DEPTH) + AW'(wptr_q[side_q])) : AW'(wptr_q[side_q]);
  assign raddr = oth ? (AW'(FIFO_DEPTH) + AW'(rptr_q[oth])) : AW'(rptr_q[oth]);

  always_comb begin
    ctl_val = '0;
    ctl_val[CTL_SEND_EMPTY] = empty[side_q];
    ctl_val[CTL_SEND_FULL]  = full[side_q];
    ctl_val[CTL_SEND_IRQ]   = send_irq_en_q[side_q];
    ctl_val[CTL_RECV_EMPTY] = empty[oth];
    ctl_val[CTL_RECV_FULL]  = full[oth];
    ctl_val[CTL_RECV_IRQ]   = recv_irq_en_q[side_q];
    ctl_val[CTL_ERROR]      = err_q[side_q];
    ctl_val[CTL_ENABLE]     = enable_q[side_q];
    sync_val = {20'd0, sync_q[side_q] & NIBBLE_MASK, 4'd0, sync_q[oth] & NIBBLE_MASK};
  end

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    ptr_next = (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      side_q  <= side_i;
      op_q    <= opcode_i;
      sel_q   <= reg_select_i;
      wdata_q <= write_data_i;
    end
  end

  // FIFO store, registered read
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[waddr] <= wdata_q;
    end
    if (do_pop) begin
      mem_rd_q <= mem[raddr];
    end
  end

  // mailbox state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < 2; q++) begin
        rptr_q[q] <= '0;
        wptr_q[q] <= '0;
        cnt_q[q]  <= '0;
        sync_q[q] <= '0;
        last_q[q] <= '0;
      end
      enable_q      <= '0;
      send_irq_en_q <= '0;
      recv_irq_en_q <= '0;
      err_q         <= '0;
      pop_q         <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        pop_q <= do_pop;
        if (op_q == OP_WRITE && sel_q == REG_SYNC) begin
          sync_q[side_q] <= wdata_q[11:8];
        end
        if (op_q == OP_WRITE && sel_q == REG_CTRL) begin
          send_irq_en_q[side_q] <= wdata_q[CTL_SEND_IRQ];
          recv_irq_en_q[side_q] <= wdata_q[CTL_RECV_IRQ];
          enable_q[side_q]      <= wdata_q[CTL_ENABLE];
          if (wdata_q[CTL_FLUSH]) begin
            rptr_q[side_q] <= '0;
            wptr_q[side_q] <= '0;
            cnt_q[side_q]  <= '0;
          end
          if (wdata_q[CTL_ERROR]) begin
            err_q[side_q] <= 1'b0;
          end
        end
        if (push_err || pop_err) begin
          err_q[side_q] <= 1'b1;
        end
        if (do_push) begin
          wptr_q[side_q] <= ptr_next(wptr_q[side_q]);
          cnt_q[side_q]  <= cnt_q[side_q] + 1'b1;
        end
        if (do_pop) begin
          rptr_q[oth] <= ptr_next(rptr_q[oth]);
          cnt_q[oth]  <= cnt_q[oth] - 1'b1;
        end
      end
      if (cmd_i.finish && pop_q) begin
        last_q[side_q] <= mem_rd_q;
      end
    end
  end

  // read value staged at execute; a pop takes the store word at finish
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (op_q == OP_READ) begin
        case (sel_q)
          REG_SYNC: stage_q <= sync_val;
          REG_CTRL: stage_q <= ctl_val;
          REG_DATA: stage_q <= last_q[side_q];
          default:  stage_q <= '0;
        endcase
      end else begin
        stage_q <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= pop_q ? mem_rd_q : stage_q;
      out_irq0_q <= irq[0];
      out_irq1_q <= irq[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_busy = out_valid_q & out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign read_data_o       = out_data_q;
  assign irq_side_zero_o   = out_irq0_q;
  assign irq_side_one_o    = out_irq1_q;

endmodule

// ----- rtl/interprocessor_fifo_mailbox.sv -----
// Interprocessor mailbox, top level: controller plus datapath.
// Order: each accepted access goes through execute, then finish, and its result is held in the output register.
// The controller takes no new access until the last one has finished, as set by the controller sequence and the
// registered read port of the FIFO store; a stalled output holds the finish step.
// Reset: pointers, counts, flags, enables, sync nibbles and last words clear at once;
// the FIFO store is not reset and needs no clearing pass.
module interprocessor_fifo_mailbox import ipcmb_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        side_i,
  input  logic        opcode_i,
  input  logic [1:0]  reg_select_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        irq_side_zero_o,
  output logic        irq_side_one_o
);

  cmd_t    cmd;
  status_t status;

  ipcmb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ipcmb_datapath #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .side_i          (side_i),
    .opcode_i        (opcode_i),
    .reg_select_i    (reg_select_i),
    .write_data_i    (write_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_o     (read_data_o),
    .irq_side_zero_o (irq_side_zero_o),
    .irq_side_one_o  (irq_side_one_o)
  );

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.exec, cmd.finish}))
    else $error("more than one datapath command at once");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (cmd.exec && in_stall_o))
    else $error("accepted transfer not executed next cycle");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !(out_valid_o && out_stall_i))
    else $error("finish overwrote a stalled result");

  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("finish did not present a result");

endmodule
